// ----- hw/rtl/nsh_pkg.sv -----
// shared types and constants for the nsec3 iterated sha-1 hash engine
package nsh_pkg;

	localparam int MaxSaltBytes = 32;
	localparam int MaxNameBytes = 255;

	localparam logic [7:0] AlgSha1     = 8'd1;
	localparam logic [7:0] WildLenByte = 8'h01;
	localparam logic [7:0] WildStar    = 8'h2a;

	localparam logic [2:0] CfgAlgorithm = 3'd0;
	localparam logic [2:0] CfgIterCount = 3'd1;
	localparam logic [2:0] CfgSaltLen   = 3'd2;
	localparam logic [2:0] CfgSaltA     = 3'd3;
	localparam logic [2:0] CfgSaltB     = 3'd4;
	localparam logic [2:0] CfgSaltC     = 3'd5;
	localparam logic [2:0] CfgSaltD     = 3'd6;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       wildcard_req;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        status;
		logic        last_word;
	} out_item_t;

	// core control: start a compression or return the chain to the initial vector; core reports done
	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	localparam logic [159:0] ShaIv =
		160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

endpackage

// ----- hw/rtl/nsec3_iterated_sha1_hash.sv -----
// nsec3 owner-name hash engine: top level with byte sequencer and sha-1 core
//  channel | dir | handshake      | payload
//  in      | in  | valid / stall  | name_byte, wildcard_req, last_byte
//  out     | out | valid / stall  | digest_word, status, last_word
//  cfg     | in  | valid / ready  | index, data (64 bits)
// a name byte is taken whenever the input is not stalled; a wildcard first byte is
// stored as 0x01, '*' and the byte; each full 64-byte block stalls the input while
// the core compresses it. after the last byte salt is absorbed one byte a cycle while
// the core is idle, then a padding block and a length block where needed; each rehash
// absorbs the digest and salt again. reset returns to the start of a name; input
// stalls outside name state or while the core works; five words (one on error) leave via the output register.
module nsec3_iterated_sha1_hash #(
	parameter int MAX_SALT_BYTES = nsh_pkg::MaxSaltBytes,
	parameter int MAX_NAME_BYTES = nsh_pkg::MaxNameBytes
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  nsh_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output nsh_pkg::out_item_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	typedef enum logic [3:0] {
		S_NAME, S_WILD2, S_WAIT, S_SALT, S_PAD, S_LEN, S_REHASH, S_OUT, S_ERR
	} state_t;

	state_t       state_q, ret_q;
	logic [7:0]   alg_q;
	logic [15:0]  iter_q, rounds_q;
	logic [5:0]   slen_q;
	logic [255:0] salt_q;
	logic [511:0] buf_q;
	logic [511:0] pad_blk;
	logic [12:0]  bits_q;
	logic         start_q, first_q;
	logic [8:0]   nbytes_q;
	logic [5:0]   sidx_q;
	logic [4:0]   didx_q;
	logic [2:0]   oidx_q;
	logic [159:0] dig_q;
	logic         last_pend_q;
	nsh_pkg::core_ctl_t ctl;
	logic         core_busy, core_done;
	logic [159:0] chain;
	logic         ov_q;
	nsh_pkg::out_item_t od_q;
	logic [5:0]   slen_eff;
	logic [5:0]   pos;
	logic         in_acc;

	assign slen_eff = (slen_q > 6'(MAX_SALT_BYTES)) ? 6'(MAX_SALT_BYTES) : slen_q;
	assign pos = bits_q[8:3];
	assign in_stall = !(state_q == S_NAME) || core_busy || start_q;
	assign in_acc = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	nsh_sha1_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .block(buf_q),
		.busy(core_busy), .done(core_done), .chain(chain)
	);

	// chain returns to the initial vector while the digest is taken or fed back for a rehash, or a name is dropped
	logic         iv_req_q;
	logic [159:0] use_chain;
	assign use_chain = chain;

	assign ctl.start = start_q;
	assign ctl.init  = iv_req_q || (state_q == S_ERR);

	// padding block: end marker, zero fill and bit length where it fits; else S_LEN adds a length block
	always_comb begin
		pad_blk = buf_q;
		for (int i = 0; i < 64; i++) begin
			if (i == int'(pos)) begin
				pad_blk[511 - 8*i -: 8] = 8'h80;
			end else if (i > int'(pos)) begin
				pad_blk[511 - 8*i -: 8] = 8'h00;
			end
		end
		if (pos < 6'd56) begin
			pad_blk[15:0] = {3'd0, bits_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q  <= nsh_pkg::AlgSha1;
			iter_q <= '0;
			slen_q <= '0;
			salt_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nsh_pkg::CfgAlgorithm: alg_q <= cfg_data[7:0];
				nsh_pkg::CfgIterCount: iter_q <= cfg_data[15:0];
				nsh_pkg::CfgSaltLen:   slen_q <= cfg_data[5:0];
				nsh_pkg::CfgSaltA:     salt_q[255:192] <= cfg_data;
				nsh_pkg::CfgSaltB:     salt_q[191:128] <= cfg_data;
				nsh_pkg::CfgSaltC:     salt_q[127:64] <= cfg_data;
				nsh_pkg::CfgSaltD:     salt_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_NAME;
			ret_q    <= S_NAME;
			bits_q   <= '0;
			start_q  <= 1'b0;
			first_q  <= 1'b1;
			nbytes_q <= '0;
			sidx_q   <= '0;
			didx_q   <= '0;
			oidx_q   <= '0;
			rounds_q <= '0;
			ov_q     <= 1'b0;
			last_pend_q <= 1'b0;
			iv_req_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_NAME: begin
					if (in_acc) begin
						first_q <= 1'b0;
						last_pend_q <= in_data.last_byte;
						if (first_q && in_data.wildcard_req) begin
							buf_q[511 - 8*pos -: 8] <= nsh_pkg::WildLenByte;
							bits_q <= bits_q + 13'd8;
							if (pos == 6'd63) start_q <= 1'b1;
							dig_q[7:0] <= in_data.name_byte;
							state_q <= S_WILD2;
						end else begin
							if (nbytes_q < 9'(MAX_NAME_BYTES)) begin
								nbytes_q <= nbytes_q + 9'd1;
								buf_q[511 - 8*pos -: 8] <= in_data.name_byte;
								bits_q <= bits_q + 13'd8;
								if (pos == 6'd63) start_q <= 1'b1;
							end
							if (in_data.last_byte) begin
								state_q <= S_WAIT;
								ret_q <= (alg_q != nsh_pkg::AlgSha1) ? S_ERR : S_SALT;
								sidx_q <= '0;
							end
						end
					end
				end
				S_WILD2: begin
					if (!core_busy && !start_q) begin
						buf_q[511 - 8*pos -: 8] <= (didx_q == 5'd0) ? nsh_pkg::WildStar
							: dig_q[7:0];
						bits_q <= bits_q + 13'd8;
						if (pos == 6'd63) start_q <= 1'b1;
						if (didx_q == 5'd0) begin
							didx_q <= 5'd1;
						end else begin
							didx_q <= '0;
							nbytes_q <= 9'd1;
							if (last_pend_q) begin
								state_q <= S_WAIT;
								ret_q <= (alg_q != nsh_pkg::AlgSha1) ? S_ERR : S_SALT;
								sidx_q <= '0;
							end else begin
								state_q <= S_NAME;
							end
						end
					end
				end
				S_WAIT: begin
					if (!core_busy && !start_q) state_q <= ret_q;
				end
				S_SALT: begin
					if (!core_busy && !start_q) begin
						if (sidx_q == slen_eff) begin
							state_q <= S_PAD;
						end else begin
							buf_q[511 - 8*pos -: 8] <= salt_q[255 - 8*sidx_q[4:0] -: 8];
							bits_q <= bits_q + 13'd8;
							sidx_q <= sidx_q + 6'd1;
							if (pos == 6'd63) start_q <= 1'b1;
						end
					end
				end
				S_PAD: begin
					if (!core_busy && !start_q) begin
						buf_q <= pad_blk;
						start_q <= 1'b1;
						state_q <= (pos > 6'd55) ? S_LEN : S_REHASH;
					end
				end
				S_LEN: begin
					if (!core_busy && !start_q) begin
						buf_q <= {496'd0, 3'd0, bits_q};
						start_q <= 1'b1;
						state_q <= S_REHASH;
						rounds_q <= rounds_q;
					end
				end
				S_REHASH: begin
					if (!core_busy && !start_q) begin
						if (!iv_req_q) begin
							iv_req_q <= 1'b1;
							rounds_q <= (rounds_q == 16'd0 && ret_q == S_SALT)
								? iter_q : rounds_q;
							ret_q <= S_REHASH;
						end else if (rounds_q == 16'd0) begin
							state_q <= S_OUT;
							dig_q <= use_chain;
							oidx_q <= '0;
							iv_req_q <= 1'b0;
						end else begin
							rounds_q <= rounds_q - 16'd1;
							buf_q[511:352] <= use_chain;
							bits_q <= 13'd160;
							sidx_q <= '0;
							state_q <= S_SALT;
							iv_req_q <= 1'b0;
						end
					end
				end
				S_OUT: begin
					if (!ov_q || !out_stall) begin
						ov_q <= 1'b1;
						od_q.digest_word <= dig_q[159 - 32*oidx_q -: 32];
						od_q.status <= 1'b0;
						od_q.last_word <= (oidx_q == 3'd4);
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd4) begin
							state_q <= S_NAME;
							bits_q <= '0;
							first_q <= 1'b1;
							nbytes_q <= '0;
							rounds_q <= '0;
							ret_q <= S_NAME;
						end
					end
				end
				S_ERR: begin
					if (!ov_q || !out_stall) begin
						ov_q <= 1'b1;
						od_q <= '{digest_word: 32'd0, status: 1'b1, last_word: 1'b1};
						state_q <= S_NAME;
						bits_q <= '0;
						first_q <= 1'b1;
						nbytes_q <= '0;
						ret_q <= S_NAME;
					end
				end
				default: state_q <= S_NAME;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_busy |-> !in_acc) else $error("input accepted during compression");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("result dropped");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !core_busy) else $error("core restarted while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> !core_busy) else $error("core busy after its last round");

endmodule

// ----- hw/rtl/nsh_sha1_core.sv -----
// sha-1 compression core, one round per cycle with a rolling 16-word schedule
module nsh_sha1_core (
	input  logic           clk,
	input  logic           arst_n,
	input  nsh_pkg::core_ctl_t ctl,
	input  logic [511:0]   block,
	output logic           busy,
	output logic           done,
	output logic [159:0]   chain
);

	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	logic [159:0] chain_q;
	logic [31:0] f, k, t, wn, wcur;

	assign wcur = w_q[0];
	assign wn = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1 |
		{31'd0, w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5a827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ed9eba1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8f1bbcdc;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hca62c1d6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wcur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			rnd_q   <= '0;
			chain_q <= nsh_pkg::ShaIv;
		end else begin
			done_q <= 1'b0;
			if (ctl.init) begin
				chain_q <= nsh_pkg::ShaIv;
			end
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				for (int i = 0; i < 16; i++) begin
					w_q[i] <= block[511 - 32*i -: 32];
				end
				a_q <= chain_q[159:128];
				b_q <= chain_q[127:96];
				c_q <= chain_q[95:64];
				d_q <= chain_q[63:32];
				e_q <= chain_q[31:0];
			end else if (busy_q) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= wn;
				e_q <= d_q;
				d_q <= c_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q;
				a_q <= t;
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					chain_q <= {chain_q[159:128] + t, chain_q[127:96] + a_q,
						chain_q[95:64] + {b_q[1:0], b_q[31:2]},
						chain_q[63:32] + c_q, chain_q[31:0] + d_q};
				end
			end
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign chain = chain_q;

endmodule
